[rtl/lfu_cache_table_core_macros.svh]
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Assertion helpers included by the LFU cache table core.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_CORE_MACROS_SVH
`define LFU_CACHE_TABLE_CORE_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define LFU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition implies another on the following edge.
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// LFU cache table package
// Sizes, entry layout and control codes shared by the LFU cache table blocks.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CAP_BITS   = 5;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [DATA_BITS-1:0]  MISS_DATA = {DATA_BITS{1'b1}};
    localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [DATA_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_BITS-1:0]   rank;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DEC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT,
        OP_EVICT
    } t_op;

endpackage

[rtl/lfu_ram.sv]
// ----------------------------------------------------------------------------
// LFU entry RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int ABITS = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lfu_cache_table_core.sv]
// ----------------------------------------------------------------------------
// LFU cache table core
// Key/value table with least-frequently-used replacement, LRU tie break.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request sweeps the entry RAM once to
// find the key and the victim, decides in S_DEC, and for a hit, an insert or
// an eviction sweeps the RAM again to rewrite ranks and counts, then loads
// the result in S_RESP. A get miss or a put at capacity zero skips the second
// sweep. After the result is loaded the block returns to idle and takes the
// next request. The sweeps read one entry at a time because the entry RAM
// has a single read port. The result register lets the next request enter
// while a result waits to be taken.
module lfu_cache_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic signed [lfu_pkg::KEY_BITS-1:0]  i_req_key,
    input  logic signed [lfu_pkg::DATA_BITS-1:0] i_req_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic signed [lfu_pkg::DATA_BITS-1:0] o_read_value,
    output logic                          o_evicted,
    output logic signed [lfu_pkg::KEY_BITS-1:0]  o_evicted_key,
    input  logic                          i_cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]  i_cfg_data
);
    import lfu_pkg::*;

`include "lfu_cache_table_core_macros.svh"

    localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(ENTRIES - 1);

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [CAP_BITS-1:0]   r_cap;
    logic [OCC_BITS-1:0]   r_occ;
    logic [ENTRIES-1:0]    r_valid;
    logic [IDX_BITS:0]     r_idx;
    logic                  r_rd_vld;
    logic [IDX_BITS-1:0]   r_rd_idx;

    logic                  r_type;
    logic [KEY_BITS-1:0]   r_key;
    logic [DATA_BITS-1:0]  r_val;

    logic                  r_m_found;
    logic [IDX_BITS-1:0]   r_m_idx;
    logic [IDX_BITS-1:0]   r_m_rank;
    logic [DATA_BITS-1:0]  r_m_data;
    logic                  r_v_found;
    logic [IDX_BITS-1:0]   r_v_idx;
    logic [IDX_BITS-1:0]   r_v_rank;
    logic [COUNT_BITS-1:0] r_v_count;
    logic [KEY_BITS-1:0]   r_v_key;

    logic [IDX_BITS-1:0]   r_slot;
    logic                  r_res_hit;
    logic [DATA_BITS-1:0]  r_res_rd;
    logic                  r_res_ev;
    logic [KEY_BITS-1:0]   r_res_evk;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [DATA_BITS-1:0]  r_out_rd;
    logic                  r_out_ev;
    logic [KEY_BITS-1:0]   r_out_evk;

    t_op                   n_op;
    logic [ENTRIES-1:0]    n_valid;
    logic [OCC_BITS-1:0]   n_occ;
    logic [IDX_BITS-1:0]   n_slot;
    logic                  n_res_hit;
    logic [DATA_BITS-1:0]  n_res_rd;
    logic                  n_res_ev;
    logic [KEY_BITS-1:0]   n_res_evk;

    t_entry                rd_entry;
    t_entry                wr_entry;
    logic [ENTRY_BITS-1:0] rd_bits;
    logic                  we;
    logic [IDX_BITS-1:0]   raddr;
    logic                  in_xfer;
    logic                  issue;
    logic                  sweep_end;
    logic [OCC_BITS-1:0]   cap_eff;
    logic [IDX_BITS-1:0]   free_ins;
    logic [IDX_BITS-1:0]   free_ev;
    logic [ENTRIES-1:0]    valid_ev;
    logic                  vk;

    assign o_ready   = (r_state == S_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign issue     = ((r_state == S_SCAN) || (r_state == S_UPD)) && !r_idx[IDX_BITS];
    assign raddr     = r_idx[IDX_BITS-1:0];
    assign sweep_end = r_rd_vld && (r_rd_idx == LAST);
    assign rd_entry  = t_entry'(rd_bits);
    assign vk        = r_valid[r_rd_idx];
    assign cap_eff   = (r_cap > CAP_BITS'(ENTRIES)) ? OCC_BITS'(ENTRIES) : OCC_BITS'(r_cap);

    lfu_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_BITS),
        .ABITS (IDX_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_rd_idx),
        .i_wdata (wr_entry),
        .i_raddr (raddr),
        .o_rdata (rd_bits)
    );

    // Lowest free slot, before and after the victim is dropped.
    always_comb begin
        valid_ev = r_valid;
        valid_ev[r_v_idx] = 1'b0;
        free_ins = '0;
        free_ev  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ins = IDX_BITS'(i);
            end
            if (!valid_ev[i]) begin
                free_ev = IDX_BITS'(i);
            end
        end
    end

    // Outcome of the scan, taken in the decision cycle.
    always_comb begin
        n_op      = OP_NONE;
        n_valid   = r_valid;
        n_occ     = r_occ;
        n_slot    = r_m_idx;
        n_res_hit = 1'b0;
        n_res_rd  = '0;
        n_res_ev  = 1'b0;
        n_res_evk = '0;
        if (r_type == REQ_GET) begin
            n_res_hit = r_m_found;
            n_res_rd  = r_m_found ? r_m_data : MISS_DATA;
            if (r_m_found) begin
                n_op = OP_TOUCH;
            end
        end else if (cap_eff != '0) begin
            if (r_m_found) begin
                n_op      = OP_TOUCH;
                n_res_hit = 1'b1;
            end else if (r_occ >= cap_eff && r_v_found) begin
                n_op             = OP_EVICT;
                n_valid          = valid_ev;
                n_valid[free_ev] = 1'b1;
                n_slot           = free_ev;
                n_res_ev         = 1'b1;
                n_res_evk        = r_v_key;
            end else begin
                n_op              = OP_INSERT;
                n_valid[free_ins] = 1'b1;
                n_occ             = r_occ + OCC_BITS'(1);
                n_slot            = free_ins;
            end
        end
    end

    // Rewrite of one entry during the update sweep.
    always_comb begin
        wr_entry = rd_entry;
        we       = (r_state == S_UPD) && r_rd_vld;
        if (r_rd_idx == r_slot) begin
            if (r_op == OP_TOUCH) begin
                wr_entry.rank = '0;
                if (rd_entry.count != COUNT_MAX) begin
                    wr_entry.count = rd_entry.count + COUNT_BITS'(1);
                end
                if (r_type == REQ_PUT) begin
                    wr_entry.data = r_val;
                end
            end else begin
                wr_entry.key   = r_key;
                wr_entry.data  = r_val;
                wr_entry.count = COUNT_BITS'(1);
                wr_entry.rank  = '0;
            end
        end else if (vk) begin
            case (r_op)
                OP_TOUCH: begin
                    if (rd_entry.rank < r_m_rank) begin
                        wr_entry.rank = rd_entry.rank + IDX_BITS'(1);
                    end
                end
                OP_INSERT: begin
                    wr_entry.rank = rd_entry.rank + IDX_BITS'(1);
                end
                OP_EVICT: begin
                    // Entries newer than the victim age by one; older ones close its gap and age, so keep their rank.
                    if (r_rd_idx != r_v_idx && rd_entry.rank <= r_v_rank) begin
                        wr_entry.rank = rd_entry.rank + IDX_BITS'(1);
                    end
                end
                default: begin
                    wr_entry = rd_entry;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer) n_state = S_SCAN;
            S_SCAN: if (sweep_end) n_state = S_DEC;
            S_DEC: begin
                if ((r_type == REQ_GET && r_m_found) ||
                    (r_type == REQ_PUT && cap_eff != '0)) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_UPD:  if (sweep_end) n_state = S_RESP;
            S_RESP: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_op        <= OP_NONE;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (issue) begin
                r_idx <= r_idx + (IDX_BITS+1)'(1);
            end else if (r_state == S_DEC || r_state == S_IDLE) begin
                r_idx <= '0;
            end
            if (r_state == S_DEC) begin
                r_op    <= n_op;
                r_valid <= n_valid;
                r_occ   <= n_occ;
            end
            if (r_state == S_RESP) begin
                if (!r_out_valid || i_ready) begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_type    <= i_req_type;
            r_key     <= i_req_key;
            r_val     <= i_req_value;
            r_m_found <= 1'b0;
            r_v_found <= 1'b0;
        end
        if (issue) begin
            r_rd_idx <= raddr;
        end
        if (r_state == S_SCAN && r_rd_vld && vk) begin
            if (!r_m_found && rd_entry.key == r_key) begin
                r_m_found <= 1'b1;
                r_m_idx   <= r_rd_idx;
                r_m_rank  <= rd_entry.rank;
                r_m_data  <= rd_entry.data;
            end
            if (!r_v_found || rd_entry.count < r_v_count ||
                (rd_entry.count == r_v_count && rd_entry.rank > r_v_rank)) begin
                r_v_found <= 1'b1;
                r_v_idx   <= r_rd_idx;
                r_v_rank  <= rd_entry.rank;
                r_v_count <= rd_entry.count;
                r_v_key   <= rd_entry.key;
            end
        end
        if (r_state == S_DEC) begin
            r_res_hit <= n_res_hit;
            r_res_rd  <= n_res_rd;
            r_res_ev  <= n_res_ev;
            r_res_evk <= n_res_evk;
            r_slot    <= n_slot;
        end
        if (r_state == S_RESP && (!r_out_valid || i_ready)) begin
            r_out_hit <= r_res_hit;
            r_out_rd  <= r_res_rd;
            r_out_ev  <= r_res_ev;
            r_out_evk <= r_res_evk;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_rd;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_evk;

    `LFU_ASSERT(a_occ_matches_valid, i_clk, i_rst_n, r_occ == OCC_BITS'($countones(r_valid)), "occupancy does not match valid bits")
    `LFU_ASSERT(a_upd_has_op, i_clk, i_rst_n, (r_state != S_UPD) || (r_op != OP_NONE), "update sweep without an operation")
    `LFU_ASSERT_NEXT(a_xfer_starts_scan, i_clk, i_rst_n, in_xfer, r_state == S_SCAN, "accepted transfer did not start a scan")

endmodule

[sim/lfu_cache_table_checker.sv]
// ----------------------------------------------------------------------------
// LFU cache table checker
// Watches the request and response channels and the capacity writes, keeps
// its own copy of the table, and compares each response with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module lfu_cache_table_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_req_valid,
    input  logic                                  i_req_ready,
    input  logic                                  i_req_type,
    input  logic signed [lfu_pkg::KEY_BITS-1:0]   i_req_key,
    input  logic signed [lfu_pkg::DATA_BITS-1:0]  i_req_value,
    input  logic                                  i_rsp_valid,
    input  logic                                  i_rsp_ready,
    input  logic                                  i_hit,
    input  logic signed [lfu_pkg::DATA_BITS-1:0]  i_read_value,
    input  logic                                  i_evicted,
    input  logic signed [lfu_pkg::KEY_BITS-1:0]   i_evicted_key,
    input  logic                                  i_cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]          i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_hits,
    output int                                    o_evictions
);
    import lfu_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic [DATA_BITS-1:0] read_value;
        logic                 evicted;
        logic [KEY_BITS-1:0]  evicted_key;
    } t_response;

    logic                  slot_valid [ENTRIES];
    logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
    logic [DATA_BITS-1:0]  slot_data  [ENTRIES];
    logic [COUNT_BITS-1:0] slot_count [ENTRIES];
    int                    slot_rank  [ENTRIES];
    int                    fill_level;
    logic [CAP_BITS-1:0]   cap_reg;
    t_response             expected_responses [$];

    assign o_pending = expected_responses.size();

    function automatic int lookup_slot(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    // Moves a slot to the front of the recency order and bumps its count.
    function automatic void promote_slot(int s);
        int r;
        r = slot_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
        slot_rank[s] = 0;
        if (slot_count[s] != COUNT_MAX) slot_count[s]++;
    endfunction

    function automatic t_response apply_request(logic rtype, logic [KEY_BITS-1:0] key,
                                                logic [DATA_BITS-1:0] value);
        t_response rsp;
        int        s;
        int        v;
        int        cap;
        rsp = '0;
        cap = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
        if (rtype == REQ_GET) begin
            s = lookup_slot(key);
            if (s >= 0) begin
                rsp.hit = 1'b1;
                rsp.read_value = slot_data[s];
                promote_slot(s);
            end else begin
                rsp.read_value = MISS_DATA;
            end
        end else if (cap != 0) begin
            s = lookup_slot(key);
            if (s >= 0) begin
                rsp.hit = 1'b1;
                slot_data[s] = value;
                promote_slot(s);
            end else begin
                if (fill_level >= cap) begin
                    v = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!slot_valid[i]) continue;
                        if (v < 0 || slot_count[i] < slot_count[v] ||
                            (slot_count[i] == slot_count[v] && slot_rank[i] > slot_rank[v]))
                            v = i;
                    end
                    if (v >= 0) begin
                        rsp.evicted = 1'b1;
                        rsp.evicted_key = slot_key[v];
                        slot_valid[v] = 1'b0;
                        for (int i = 0; i < ENTRIES; i++)
                            if (slot_valid[i] && slot_rank[i] > slot_rank[v]) slot_rank[i]--;
                        fill_level--;
                    end
                end
                s = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (!slot_valid[i] && s < 0) s = i;
                if (s >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_valid[i]) slot_rank[i]++;
                    slot_valid[s] = 1'b1;
                    slot_key[s]   = key;
                    slot_data[s]  = value;
                    slot_count[s] = 1;
                    slot_rank[s]  = 0;
                    fill_level++;
                end
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_response want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
            fill_level = 0;
            cap_reg = CAP_RESET;
            expected_responses.delete();
            o_fail_count = 0;
            o_hits = 0;
            o_evictions = 0;
        end else begin
            // The response is checked before this edge's request is predicted; the
            // block cannot answer a request in the cycle it takes it.
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_responses.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_responses.pop_front();
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_hit);
                        o_fail_count++;
                    end
                    if (i_read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               i_read_value);
                        o_fail_count++;
                    end
                    if (i_evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, i_evicted);
                        o_fail_count++;
                    end
                    if (i_evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %h, got %h", want.evicted_key,
                               i_evicted_key);
                        o_fail_count++;
                    end
                    if (want.hit) o_hits++;
                    if (want.evicted) o_evictions++;
                end
            end
            if (i_req_valid && i_req_ready)
                expected_responses.push_back(apply_request(i_req_type, i_req_key, i_req_value));
            if (i_cfg_we) cap_reg = i_cfg_data;
        end
    end
endmodule

[sim/tb_lfu_cache_table_core.sv]
// ----------------------------------------------------------------------------
// LFU cache table core testbench
// Drives get and put requests under several capacities and flow-control
// patterns; the checker predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table_core;
    import lfu_pkg::*;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    logic                        req_type = REQ_GET;
    logic signed [KEY_BITS-1:0]  req_key = '0;
    logic signed [DATA_BITS-1:0] req_value = '0;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    logic                        rsp_hit;
    logic signed [DATA_BITS-1:0] rsp_read_value;
    logic                        rsp_evicted;
    logic signed [KEY_BITS-1:0]  rsp_evicted_key;
    logic                        cfg_we = 1'b0;
    logic [CAP_BITS-1:0]         cfg_data = '0;
    int                          fail_count;
    int                          pending;
    int                          hit_total;
    int                          evict_total;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    bit                          recv_hold = 1'b0;
    int                          sent = 0;
    logic [KEY_BITS-1:0]         key_pool [8];

    always #4 i_clk = ~i_clk;

    lfu_cache_table_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_req_type(req_type), .i_req_key(req_key), .i_req_value(req_value),
        .o_valid(rsp_valid), .i_ready(rsp_ready),
        .o_hit(rsp_hit), .o_read_value(rsp_read_value),
        .o_evicted(rsp_evicted), .o_evicted_key(rsp_evicted_key),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    lfu_cache_table_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .i_req_ready(req_ready),
        .i_req_type(req_type), .i_req_key(req_key), .i_req_value(req_value),
        .i_rsp_valid(rsp_valid), .i_rsp_ready(rsp_ready),
        .i_hit(rsp_hit), .i_read_value(rsp_read_value),
        .i_evicted(rsp_evicted), .i_evicted_key(rsp_evicted_key),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hits(hit_total), .o_evictions(evict_total)
    );

    // Response side: random stalls, or a long hold while recv_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_ready <= 1'b0;
        else rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one request and returns at the edge that takes it, with random idle
    // gaps. Valid stays high after the transfer until the next gap or drain.
    task automatic send_request(logic rtype, logic [KEY_BITS-1:0] key,
                                logic [DATA_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_type  <= rtype;
        req_key   <= key;
        req_value <= value;
        do @(posedge i_clk); while (!req_ready);
        sent++;
    endtask

    task automatic drain_and_set_capacity(logic [CAP_BITS-1:0] cap);
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Keys mostly come from a small pool so that hits, updates and evictions are
    // frequent; the rest are fully random.
    task automatic random_request();
        logic [KEY_BITS-1:0] key;
        key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(7)];
        send_request(logic'($urandom_range(1)), key, $urandom);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme keys and values, full table, eviction ties, misses.
        send_request(REQ_GET, 32'h8000_0000, 32'h0);
        send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'h7FFF_FFFF, 32'h1234_5678);
        send_request(REQ_PUT, 32'h8000_0000, 32'h0);
        for (int i = 0; i < 14; i++) send_request(REQ_PUT, i, ~i);
        send_request(REQ_PUT, 32'h0000_0000, 32'hAAAA_5555);
        send_request(REQ_GET, 32'h0000_0000, 32'h0);
        drain_and_set_capacity(5'd0);
        send_request(REQ_PUT, 32'h5555_AAAA, 32'h1);
        send_request(REQ_GET, 32'h7FFF_FFFF, 32'h0);
        drain_and_set_capacity(5'd2);
        send_request(REQ_PUT, 32'h5555_AAAA, 32'h2);

        // Long receiver hold so the block backs up and stalls its input.
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_request(REQ_GET, i, 0);
        join

        for (int phase = 0; phase < 9; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 33; recv_idle_pct = 76; end
                1: begin send_idle_pct = 76; recv_idle_pct = 33; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 8; k++) key_pool[k] = (phase < 3) ? k : $urandom;
            drain_and_set_capacity(phase == 3 ? 5'd31 : phase == 6 ? 5'd1 :
                                   CAP_BITS'($urandom_range(16)));
            for (int n = 0; n < 190; n++) random_request();
        end
        drain_and_set_capacity(5'd16);
        for (int n = 0; n < 40; n++) random_request();

        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests over capacities 0 to 31 and three flow-control mixes.",
                 sent);
        $display("Responses: %0d hits, %0d evictions.", hit_total, evict_total);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cache_table_core.sv
sim/lfu_cache_table_checker.sv
sim/tb_lfu_cache_table_core.sv
